// ===== rtl/core/ccnp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccnp_pkg
// Shared types, character codes and helpers for the character-class parser.
// ----------------------------------------------------------------------------
package ccnp_pkg;

    // Set geometry
    localparam int SET_VALUES  = 256;
    localparam int WORD_BITS   = 64;
    localparam int WORD_COUNT  = SET_VALUES / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(WORD_COUNT);

    // Operation queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Operation handed from front to back: an optional range add, an optional
    // literal hyphen add, and an optional emit of the whole set.
    typedef struct packed {
        logic       add_en;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       dash_en;
        logic       emit;
        logic       status;
        logic       negate;
    } t_op;

    // Map an escaped byte to the byte it stands for
    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            CH_N:    r = CH_LF;
            CH_R:    r = CH_CR;
            CH_T:    r = CH_TAB;
            CH_ZERO: r = CH_NUL;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/ccnp_front.sv =====
// ----------------------------------------------------------------------------
// ccnp_front
// Input side: tracks the parse phase byte by byte and turns each beat into
// at most one set operation for the back end.
// ----------------------------------------------------------------------------
module ccnp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_ch,
    input  logic            i_end_of_spec,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output ccnp_pkg::t_op   o_op
);

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_ESC_LOW   = 5'b00010,
        PH_HAVE_LOW  = 5'b00100,
        PH_HAVE_DASH = 5'b01000,
        PH_ESC_HIGH  = 5'b10000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [7:0]    r_low, n_low;
    logic          r_neg, n_neg;
    logic          r_first, n_first;
    ccnp_pkg::t_op op;
    logic          op_valid;
    logic          accept;
    logic [7:0]    hi_byte;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept && op_valid;
    assign o_op    = op;

    // High end of a range: escaped in the high-escape phase, raw otherwise
    assign hi_byte = (r_phase == PH_ESC_HIGH) ? ccnp_pkg::decode_escape(i_ch) : i_ch;

    // Parse step
    always_comb begin
        n_phase  = r_phase;
        n_low    = r_low;
        n_neg    = r_neg;
        n_first  = r_first;
        op       = '0;
        op_valid = 1'b0;
        if (!i_end_of_spec) begin
            n_first = 1'b0;
            if (r_first && i_ch == ccnp_pkg::CH_CARET) begin
                n_neg   = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                unique case (r_phase)
                    PH_ESC_LOW: begin
                        n_low   = ccnp_pkg::decode_escape(i_ch);
                        n_phase = PH_HAVE_LOW;
                    end
                    PH_HAVE_LOW: begin
                        if (i_ch == ccnp_pkg::CH_DASH) begin
                            n_phase = PH_HAVE_DASH;
                        end else begin
                            // flush the held byte, then start a new atom
                            op.add_en = 1'b1;
                            op.lo     = r_low;
                            op.hi     = r_low;
                            op_valid  = 1'b1;
                            if (i_ch == ccnp_pkg::CH_BSLASH) begin
                                n_phase = PH_ESC_LOW;
                            end else begin
                                n_low   = i_ch;
                                n_phase = PH_HAVE_LOW;
                            end
                        end
                    end
                    PH_HAVE_DASH, PH_ESC_HIGH: begin
                        if (r_phase == PH_HAVE_DASH && i_ch == ccnp_pkg::CH_BSLASH) begin
                            n_phase = PH_ESC_HIGH;
                        end else begin
                            // reversed ranges are swapped here
                            op.add_en = 1'b1;
                            op.lo     = (r_low <= hi_byte) ? r_low : hi_byte;
                            op.hi     = (r_low <= hi_byte) ? hi_byte : r_low;
                            op_valid  = 1'b1;
                            n_phase   = PH_IDLE;
                        end
                    end
                    default: begin
                        if (i_ch == ccnp_pkg::CH_BSLASH) begin
                            n_phase = PH_ESC_LOW;
                        end else begin
                            n_low   = i_ch;
                            n_phase = PH_HAVE_LOW;
                        end
                    end
                endcase
            end
        end else begin
            // end of body: settle what is held, emit, start afresh
            op.emit   = 1'b1;
            op.negate = r_neg;
            op_valid  = 1'b1;
            unique case (r_phase)
                PH_ESC_LOW, PH_ESC_HIGH: op.status = 1'b1;
                PH_HAVE_LOW: begin
                    op.add_en = 1'b1;
                    op.lo     = r_low;
                    op.hi     = r_low;
                end
                PH_HAVE_DASH: begin
                    op.add_en  = 1'b1;
                    op.lo      = r_low;
                    op.hi      = r_low;
                    op.dash_en = 1'b1;
                end
                default: op.status = 1'b0;
            endcase
            n_phase = PH_IDLE;
            n_low   = '0;
            n_neg   = 1'b0;
            n_first = 1'b1;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_low   <= '0;
            r_neg   <= 1'b0;
            r_first <= 1'b1;
        end else if (accept) begin
            r_phase <= n_phase;
            r_low   <= n_low;
            r_neg   <= n_neg;
            r_first <= n_first;
        end
    end

endmodule

// ===== rtl/core/ccnp_queue.sv =====
// ----------------------------------------------------------------------------
// ccnp_queue
// Short register queue of set operations between the front and back ends.
// ----------------------------------------------------------------------------
module ccnp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ccnp_pkg::t_op   i_op,
    input  logic            i_pop,
    output ccnp_pkg::t_op   o_op,
    output logic            o_empty,
    output logic            o_full
);

    ccnp_pkg::t_op                    r_mem [ccnp_pkg::QUEUE_DEPTH];
    logic [ccnp_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [ccnp_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [ccnp_pkg::QCNT_W-1:0]      r_count;
    logic                             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == ccnp_pkg::QCNT_W'(ccnp_pkg::QUEUE_DEPTH));
    assign o_op    = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/ccnp_back.sv =====
// ----------------------------------------------------------------------------
// ccnp_back
// Execution side: holds the 256-bit member set, applies range adds one per
// cycle when not emitting and streams the set out as four words on an emit.
// ----------------------------------------------------------------------------
module ccnp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ccnp_pkg::t_op                     i_op,
    input  logic                              i_op_valid,
    output logic                              o_pop,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [ccnp_pkg::WORD_BITS-1:0]    o_set_word,
    output logic [1:0]                        o_word_index,
    output logic                              o_last_word,
    output logic                              o_status
);

    logic [ccnp_pkg::SET_VALUES-1:0]   r_set;
    logic [ccnp_pkg::SET_VALUES-1:0]   mask;
    logic                              r_emitting;
    logic [ccnp_pkg::WORD_IDX_W-1:0]   r_word_cnt;
    logic                              r_emit_status;
    logic                              r_emit_neg;
    logic                              r_o_valid;
    logic [ccnp_pkg::WORD_BITS-1:0]    r_o_word;
    logic [1:0]                        r_o_index;
    logic                              r_o_last;
    logic                              r_o_status;
    logic                              load;
    logic [ccnp_pkg::WORD_BITS-1:0]    cur_word;

    // Take the next op only while no set is being streamed out
    assign o_pop = i_op_valid && !r_emitting;
    assign load  = r_emitting && (!r_o_valid || !i_stall);

    // Range mask over every set value
    always_comb begin
        for (int i = 0; i < ccnp_pkg::SET_VALUES; i++) begin
            mask[i] = (i_op.add_en && 8'(i) >= i_op.lo && 8'(i) <= i_op.hi)
                   || (i_op.dash_en && 8'(i) == ccnp_pkg::CH_DASH);
        end
    end

    // Word under the emit counter; negation only on a clean parse
    always_comb begin
        cur_word = r_set[r_word_cnt * ccnp_pkg::WORD_BITS +: ccnp_pkg::WORD_BITS];
        if (!r_emit_status && r_emit_neg) begin
            cur_word = ~cur_word;
        end
    end

    // Set and emit sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set         <= '0;
            r_emitting    <= 1'b0;
            r_word_cnt    <= '0;
            r_emit_status <= 1'b0;
            r_emit_neg    <= 1'b0;
        end else if (o_pop) begin
            r_set <= r_set | mask;
            if (i_op.emit) begin
                r_emitting    <= 1'b1;
                r_word_cnt    <= '0;
                r_emit_status <= i_op.status;
                r_emit_neg    <= i_op.negate;
            end
        end else if (load) begin
            r_word_cnt <= r_word_cnt + 1'b1;
            if (r_word_cnt == ccnp_pkg::WORD_IDX_W'(ccnp_pkg::WORD_COUNT - 1)) begin
                r_emitting <= 1'b0;
                r_set      <= '0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_word   <= cur_word;
            r_o_index  <= 2'(r_word_cnt);
            r_o_last   <= (r_word_cnt == ccnp_pkg::WORD_IDX_W'(ccnp_pkg::WORD_COUNT - 1));
            r_o_status <= r_emit_status;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_set_word   = r_o_word;
    assign o_word_index = r_o_index;
    assign o_last_word  = r_o_last;
    assign o_status     = r_o_status;

`ifndef SYNTHESIS
    // final beat of a set always carries the top word index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_last |-> r_o_index == 2'(ccnp_pkg::WORD_COUNT - 1))
        else $error("last beat without top word index");

    // set is empty once streaming ends
    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_emitting) |-> r_set == '0)
        else $error("set not cleared after emit");

    // mid-stream, an earlier word has already been loaded
    a_word_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting && r_word_cnt != '0 |-> r_o_valid)
        else $error("emit counter ran ahead of output register");

    // no op is taken while a set is going out
    a_no_pop_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting |-> !o_pop)
        else $error("op popped during emit");
`endif

endmodule

// ===== rtl/core/char_class_notation_parser.sv =====
// ----------------------------------------------------------------------------
// char_class_notation_parser
// Builds a 256-member byte set from a character-class body, one byte a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one body byte per beat on i_ch, or an
//   end beat with i_end_of_spec high (i_ch ignored). A beat is taken at a
//   rising edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall): an end beat yields four beats, word
//   index 0..3, o_last_word high on the fourth; o_status flags a trailing
//   backslash (set then sent unnegated). Byte beats yield no output.
//   Throughput: one byte beat per cycle while o_stall is low. The front
//   parser feeds a four-entry operation queue; the back end applies one range
//   add per cycle while no set is streaming out. An end beat takes the back
//   end one step to fold in the held atom, then four loads of the output
//   register, and no further op is taken until the last word is loaded. The
//   end beat's op passes through the queue before its first word is loaded.
//   Stall: i_stall holds the output register; the back end waits, the queue
//   fills and o_stall rises only when it is full.
//   Reset (i_rst_n low, synchronous): empty set, no negation, queue and
//   output register emptied; the next byte counts as the first of a body.
// ----------------------------------------------------------------------------
module char_class_notation_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_ch,
    input  logic                              i_end_of_spec,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ccnp_pkg::WORD_BITS-1:0]    o_set_word,
    output logic [1:0]                        o_word_index,
    output logic                              o_last_word,
    output logic                              o_status
);

    ccnp_pkg::t_op  push_op;
    ccnp_pkg::t_op  head_op;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;

    ccnp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ch          (i_ch),
        .i_end_of_spec (i_end_of_spec),
        .i_q_full      (q_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_op          (push_op)
    );

    ccnp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ccnp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (head_op),
        .i_op_valid   (!q_empty),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_set_word   (o_set_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_status     (o_status)
    );

endmodule

// ===== bench/char_class_notation_parser_test.sv =====
// ----------------------------------------------------------------------------
// char_class_notation_parser_test
// Self-checking bench for the character-class body parser. Body bytes and end
// beats go in over a valid/stall channel with random gaps; each end beat must
// produce four set words. A local parser model predicts the untyped words, and a
// short directed table with typed-in sets for the obvious cases comes first.
// ----------------------------------------------------------------------------
module char_class_notation_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles allowed before the run is declared hung. This is far above
    // the longest random send gap and output stall the bench draws, plus the
    // pipeline.
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_BEATS  = 385;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [ccnp_pkg::WORD_BITS-1:0] EMPTY_WORD = '0;
    localparam logic [ccnp_pkg::WORD_BITS-1:0] FULL_WORD  = '1;

    // Where the parser stands between body bytes
    typedef enum logic [4:0] {
        SCAN_OPEN      = 5'b00001,
        SCAN_ESC_LOW   = 5'b00010,
        SCAN_HOLD_LOW  = 5'b00100,
        SCAN_HOLD_DASH = 5'b01000,
        SCAN_ESC_HIGH  = 5'b10000
    } t_scan;

    // One output beat as expected
    typedef struct packed {
        logic [ccnp_pkg::WORD_BITS-1:0] word;
        logic [1:0]                     index;
        logic                           last;
        logic                           err;
    } t_set_word;

    // Directed stimulus row; typed rows carry the word all four quarters share
    typedef struct packed {
        logic [7:0]                     ch;
        logic                           eos;
        logic                           typed;
        logic [ccnp_pkg::WORD_BITS-1:0] word;
        logic                           err;
    } t_plan_row;

    localparam int PLAN_ROWS = 28;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // empty body
        '{8'hFF,               1'b1, 1'b1, EMPTY_WORD, 1'b0},
        // lone caret: full set
        '{ccnp_pkg::CH_CARET,  1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{8'h00,               1'b1, 1'b1, FULL_WORD,  1'b0},
        // trailing backslash with nothing escaped
        '{ccnp_pkg::CH_BSLASH, 1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{8'hA5,               1'b1, 1'b1, EMPTY_WORD, 1'b1},
        // negated, range cut short by a trailing backslash: nothing kept
        '{ccnp_pkg::CH_CARET,  1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{"a",                 1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_DASH,   1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_BSLASH, 1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{8'h00,               1'b1, 1'b1, EMPTY_WORD, 1'b1},
        // full byte range from the extremes, zero byte as a member
        '{8'h00,               1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_DASH,   1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{8'hFF,               1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{8'h5A,               1'b1, 1'b1, FULL_WORD,  1'b0},
        // escaped n, reversed range, late caret, hyphen at the end
        '{ccnp_pkg::CH_BSLASH, 1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_N,      1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{"z",                 1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_DASH,   1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{"a",                 1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_CARET,  1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_DASH,   1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{8'h00,               1'b1, 1'b0, EMPTY_WORD, 1'b0},
        // escaped r down to escaped 0
        '{ccnp_pkg::CH_BSLASH, 1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_R,      1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_DASH,   1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_BSLASH, 1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{ccnp_pkg::CH_ZERO,   1'b0, 1'b0, EMPTY_WORD, 1'b0},
        '{8'h33,               1'b1, 1'b0, EMPTY_WORD, 1'b0}
    };

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_valid       = 1'b0;
    logic [7:0]                     i_ch          = 8'h00;
    logic                           i_end_of_spec = 1'b0;
    logic                           i_stall       = 1'b0;
    logic                           o_stall;
    logic                           o_valid;
    logic [ccnp_pkg::WORD_BITS-1:0] o_set_word;
    logic [1:0]                     o_word_index;
    logic                           o_last_word;
    logic                           o_status;

    char_class_notation_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_end_of_spec (i_end_of_spec),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_set_word    (o_set_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .o_status      (o_status)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    logic [ccnp_pkg::WORD_BITS-1:0] class_bits [ccnp_pkg::WORD_COUNT];
    t_scan                          scan_state;
    logic [7:0]                     held_low;
    logic                           invert_set;
    logic                           expect_first;
    logic [ccnp_pkg::WORD_BITS-1:0] emit_words [ccnp_pkg::WORD_COUNT];
    logic                           emit_err;

    t_set_word pending_words [$];
    int        fault_count = 0;
    int        beats_sent  = 0;
    bit        send_calm   = 1'b0;
    bit        drain_calm  = 1'b0;

    function automatic void clear_class();
        int k;
        for (k = 0; k < ccnp_pkg::WORD_COUNT; k++) class_bits[k] = '0;
        scan_state   = SCAN_OPEN;
        held_low     = 8'h00;
        invert_set   = 1'b0;
        expect_first = 1'b1;
    endfunction

    function automatic logic [7:0] unescape_byte(input logic [7:0] c);
        case (c)
            ccnp_pkg::CH_N:    return ccnp_pkg::CH_LF;
            ccnp_pkg::CH_R:    return ccnp_pkg::CH_CR;
            ccnp_pkg::CH_T:    return ccnp_pkg::CH_TAB;
            ccnp_pkg::CH_ZERO: return ccnp_pkg::CH_NUL;
            default:           return c;
        endcase
    endfunction

    // Inclusive span, either order
    function automatic void mark_span(input logic [7:0] a, input logic [7:0] b);
        int lo;
        int hi;
        int v;
        lo = (a <= b) ? a : b;
        hi = (a <= b) ? b : a;
        for (v = lo; v <= hi; v++)
            class_bits[v / ccnp_pkg::WORD_BITS][v % ccnp_pkg::WORD_BITS] = 1'b1;
    endfunction

    function automatic void open_atom(input logic [7:0] c);
        if (c == ccnp_pkg::CH_BSLASH) begin
            scan_state = SCAN_ESC_LOW;
        end else begin
            held_low   = c;
            scan_state = SCAN_HOLD_LOW;
        end
    endfunction

    // Returns 1 when the beat closes the body; emit_words/emit_err then hold the set
    function automatic bit parse_class_byte(input logic [7:0] c, input logic eos);
        int k;
        if (!eos) begin
            if (expect_first) begin
                expect_first = 1'b0;
                if (c == ccnp_pkg::CH_CARET) begin
                    invert_set = 1'b1;
                    scan_state = SCAN_OPEN;
                    return 1'b0;
                end
            end
            case (scan_state)
                SCAN_ESC_LOW: begin
                    held_low   = unescape_byte(c);
                    scan_state = SCAN_HOLD_LOW;
                end
                SCAN_HOLD_LOW: begin
                    if (c == ccnp_pkg::CH_DASH) begin
                        scan_state = SCAN_HOLD_DASH;
                    end else begin
                        mark_span(held_low, held_low);
                        open_atom(c);
                    end
                end
                SCAN_HOLD_DASH: begin
                    if (c == ccnp_pkg::CH_BSLASH) begin
                        scan_state = SCAN_ESC_HIGH;
                    end else begin
                        mark_span(held_low, c);
                        scan_state = SCAN_OPEN;
                    end
                end
                SCAN_ESC_HIGH: begin
                    mark_span(held_low, unescape_byte(c));
                    scan_state = SCAN_OPEN;
                end
                default: begin
                    open_atom(c);
                end
            endcase
            return 1'b0;
        end

        // end of body: fold in what is still held
        emit_err = 1'b0;
        case (scan_state)
            SCAN_ESC_LOW, SCAN_ESC_HIGH: begin
                emit_err = 1'b1;
            end
            SCAN_HOLD_LOW: begin
                mark_span(held_low, held_low);
            end
            SCAN_HOLD_DASH: begin
                mark_span(held_low, held_low);
                mark_span(ccnp_pkg::CH_DASH, ccnp_pkg::CH_DASH);
            end
            default: begin
            end
        endcase
        for (k = 0; k < ccnp_pkg::WORD_COUNT; k++)
            emit_words[k] = (!emit_err && invert_set) ? ~class_bits[k] : class_bits[k];
        clear_class();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Send side
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] c, input logic eos,
                             input logic typed = 1'b0,
                             input logic [ccnp_pkg::WORD_BITS-1:0] typed_word = '0,
                             input logic typed_err = 1'b0);
        int gap;
        int k;
        if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_ch          <= c;
        i_end_of_spec <= eos;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        beats_sent++;
        if (parse_class_byte(c, eos)) begin
            for (k = 0; k < ccnp_pkg::WORD_COUNT; k++)
                pending_words.push_back('{typed ? typed_word : emit_words[k], 2'(k),
                                          k == ccnp_pkg::WORD_COUNT - 1,
                                          typed ? typed_err : emit_err});
        end
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 8))
                0: return ccnp_pkg::CH_CARET;
                1: return ccnp_pkg::CH_BSLASH;
                2: return ccnp_pkg::CH_DASH;
                3: return ccnp_pkg::CH_N;
                4: return ccnp_pkg::CH_R;
                5: return ccnp_pkg::CH_T;
                6: return ccnp_pkg::CH_ZERO;
                7: return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Literal or escaped byte
    task automatic send_atom();
        logic [7:0] b;
        b = pick_byte();
        if (b == ccnp_pkg::CH_BSLASH || $urandom_range(0, 3) == 0) begin
            send_beat(ccnp_pkg::CH_BSLASH, 1'b0);
            send_beat(pick_byte(), 1'b0);
        end else begin
            send_beat(b, 1'b0);
        end
    endtask

    // Mostly well-formed bodies with random content, some raw noise
    task automatic send_random_body();
        int atoms;
        int k;
        if ($urandom_range(0, 9) == 0) begin
            atoms = $urandom_range(0, 10);
            for (k = 0; k < atoms; k++) send_beat(pick_byte(), 1'b0);
        end else begin
            if ($urandom_range(0, 2) == 0) send_beat(ccnp_pkg::CH_CARET, 1'b0);
            atoms = $urandom_range(0, 6);
            for (k = 0; k < atoms; k++) begin
                send_atom();
                if ($urandom_range(0, 1) == 0) begin
                    send_beat(ccnp_pkg::CH_DASH, 1'b0);
                    send_atom();
                end
            end
            // awkward endings
            case ($urandom_range(0, 7))
                0: send_beat(ccnp_pkg::CH_BSLASH, 1'b0);
                1: begin
                    send_atom();
                    send_beat(ccnp_pkg::CH_DASH, 1'b0);
                end
                2: begin
                    send_atom();
                    send_beat(ccnp_pkg::CH_DASH, 1'b0);
                    send_beat(ccnp_pkg::CH_BSLASH, 1'b0);
                end
                default: begin
                end
            endcase
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        int r;
        clear_class();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < PLAN_ROWS; r++)
            send_beat(PLAN[r].ch, PLAN[r].eos, PLAN[r].typed, PLAN[r].word, PLAN[r].err);
        while (beats_sent < PLAN_ROWS + RANDOM_BEATS) send_random_body();
        i_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("char_class_notation_parser_test: done, clean");
        end else begin
            $display("char_class_notation_parser_test: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receive side: random stall, compare each word with the oldest expected
    // ------------------------------------------------------------------------
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin : recv
        bit        taken;
        int        n;
        t_set_word want;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else begin
            taken = (o_valid === 1'b1) && !i_stall;
            if (taken) begin
                if (pending_words.size() == 0) begin
                    if (fault_count < 10)
                        $display("unexpected set word: word=%h index=%0d last=%b status=%b",
                                 o_set_word, o_word_index, o_last_word, o_status);
                    fault_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (o_set_word !== want.word || o_word_index !== want.index ||
                        o_last_word !== want.last || o_status !== want.err) begin
                        // word, index, last, status
                        if (fault_count < 10)
                            $display("mismatch: expected %h %0d %b %b, got %h %0d %b %b",
                                     want.word, want.index, want.last, want.err,
                                     o_set_word, o_word_index, o_last_word, o_status);
                        fault_count++;
                    end
                end
            end

            if (hold_left > 1) begin
                hold_left <= hold_left - 1;
            end else if (hold_left == 1) begin
                hold_left <= 0;
                i_stall   <= 1'b0;
            end else if (taken || (o_valid !== 1'b1 && $urandom_range(0, 3) == 0)) begin
                // fresh stall for the next beat; also thrown in while idle
                if ($urandom_range(0, 39) == 0) drain_calm = ~drain_calm;
                n = drain_calm ? 0 : $urandom_range(0, 13);
                hold_left <= n;
                i_stall   <= (n > 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no beat on either side for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("char_class_notation_parser_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
